// ----- sv/fssm_pkg.sv -----
// shared types, constants and codes of the flow start/stop meter
`default_nettype none

package fssm_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 32;

   localparam int CFG_WIDTH     = 16;
   localparam int TIME_WIDTH    = 32;
   localparam int MAG_WIDTH     = 31;
   localparam int LITERS_WIDTH  = 31;
   localparam int PRICE_WIDTH   = 47;
   localparam int TOTAL_WIDTH   = 32;
   localparam int MODE_WIDTH    = 2;
   localparam int TIMEOUT_WIDTH = 26;
   localparam int ADD_WIDTH     = 48;

   localparam int ADDR_WIDTH    = 5;
   localparam int DATA_WIDTH    = 32;
   localparam int INDEX_WIDTH   = 3;

   localparam int MS_PER_S      = 1000;

   localparam int DIV_STEPS     = 31;
   localparam int MUL_STEPS     = 16;
   localparam int STEP_WIDTH    = 5;

   localparam logic [CFG_WIDTH-1:0] MIN_DELTA_RESET        = 16'd3;
   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_MS_RESET      = 16'd20;
   localparam logic [CFG_WIDTH-1:0] STOP_TIMEOUT_S_RESET   = 16'd15;
   localparam logic [CFG_WIDTH-1:0] PULSES_PER_LITER_RESET = 16'd100;
   localparam logic [CFG_WIDTH-1:0] UNIT_PRICE_RESET       = 16'd0;

   typedef enum logic [INDEX_WIDTH-1:0] {
      REG_MIN_DELTA,
      REG_DEBOUNCE_MS,
      REG_STOP_TIMEOUT_S,
      REG_PULSES_PER_LITER,
      REG_UNIT_PRICE
   } reg_index_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_IDLE,
      MODE_SERVICE,
      MODE_SALE
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SALE_MUL,
      ST_SALE_TAKE,
      ST_DIVIDE,
      ST_PRICE_LOAD,
      ST_PRICE_MUL,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] min_delta;
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] stop_timeout_s;
      logic [CFG_WIDTH-1:0] pulses_per_liter;
      logic [CFG_WIDTH-1:0] unit_price;
   } cfg_type;

   typedef struct packed {
      logic req_ready;
      logic decide;
      logic sale_capture;
      logic load_div;
      logic load_mul;
      logic mul_src_sale;
      logic step_div;
      logic step_mul;
      logic result_load;
   } seq_ctl_type;

   typedef struct packed {
      logic req_valid;
      logic need_sale;
      logic rsp_free;
   } seq_status_type;

endpackage

`default_nettype wire

// ----- sv/fssm_csr.sv -----
// configuration registers behind the apb-style port
`default_nettype none

module fssm_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [fssm_pkg::ADDR_WIDTH-1:0]    paddr,
   input  wire logic [fssm_pkg::DATA_WIDTH-1:0]    pwdata,
   output logic      [fssm_pkg::DATA_WIDTH-1:0]    prdata,
   output logic                                    pready,
   output fssm_pkg::cfg_type                       cfg
);

   fssm_pkg::cfg_type       cfg_ff;
   fssm_pkg::cfg_type       cfg_in;
   fssm_pkg::reg_index_type index;
   logic                    write_en;
   logic [fssm_pkg::CFG_WIDTH-1:0] wdata;
   logic [fssm_pkg::CFG_WIDTH-1:0] rdata;

   assign index    = fssm_pkg::reg_index_type'(paddr[fssm_pkg::ADDR_WIDTH-1:2]);
   assign write_en = psel & penable & pwrite;
   assign wdata    = pwdata[fssm_pkg::CFG_WIDTH-1:0];
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            fssm_pkg::REG_MIN_DELTA:        cfg_in.min_delta        = wdata;
            fssm_pkg::REG_DEBOUNCE_MS:      cfg_in.debounce_ms      = wdata;
            fssm_pkg::REG_STOP_TIMEOUT_S:   cfg_in.stop_timeout_s   = wdata;
            fssm_pkg::REG_PULSES_PER_LITER: cfg_in.pulses_per_liter = wdata;
            fssm_pkg::REG_UNIT_PRICE:       cfg_in.unit_price       = wdata;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         fssm_pkg::REG_MIN_DELTA:        rdata = cfg_ff.min_delta;
         fssm_pkg::REG_DEBOUNCE_MS:      rdata = cfg_ff.debounce_ms;
         fssm_pkg::REG_STOP_TIMEOUT_S:   rdata = cfg_ff.stop_timeout_s;
         fssm_pkg::REG_PULSES_PER_LITER: rdata = cfg_ff.pulses_per_liter;
         fssm_pkg::REG_UNIT_PRICE:       rdata = cfg_ff.unit_price;
         default:                        rdata = '0;
      endcase
   end

   assign prdata = fssm_pkg::DATA_WIDTH'(rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_delta        <= fssm_pkg::MIN_DELTA_RESET;
         cfg_ff.debounce_ms      <= fssm_pkg::DEBOUNCE_MS_RESET;
         cfg_ff.stop_timeout_s   <= fssm_pkg::STOP_TIMEOUT_S_RESET;
         cfg_ff.pulses_per_liter <= fssm_pkg::PULSES_PER_LITER_RESET;
         cfg_ff.unit_price       <= fssm_pkg::UNIT_PRICE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/fssm_alu.sv -----
// shared add/subtract unit doing restoring divide and shift-add multiply steps
`default_nettype none

module fssm_alu (
   input  wire logic                                   clock,
   input  wire fssm_pkg::seq_ctl_type                  ctl,
   input  wire logic [fssm_pkg::MAG_WIDTH-1:0]         dividend,
   input  wire logic [fssm_pkg::CFG_WIDTH-1:0]         divisor,
   input  wire logic [fssm_pkg::LITERS_WIDTH-1:0]      sale_liters,
   input  wire logic [fssm_pkg::CFG_WIDTH-1:0]         multiplier,
   output logic      [fssm_pkg::LITERS_WIDTH-1:0]      quotient,
   output logic      [fssm_pkg::PRICE_WIDTH-1:0]       product
);

   localparam int AW = fssm_pkg::ADD_WIDTH;
   localparam int CW = fssm_pkg::CFG_WIDTH;
   localparam int QW = fssm_pkg::LITERS_WIDTH;
   localparam int PW = fssm_pkg::PRICE_WIDTH;

   logic [CW-1:0] rem_ff,   rem_in;
   logic [QW-1:0] quo_ff,   quo_in;
   logic [CW-1:0] dvs_ff,   dvs_in;
   logic [QW-1:0] mcand_ff, mcand_in;
   logic [CW-1:0] mpr_ff,   mpr_in;
   logic [PW-1:0] acc_ff,   acc_in;

   logic [AW-1:0] add_a;
   logic [AW-1:0] add_b;
   logic          add_sub;
   logic [AW-1:0] sum;
   logic          fits;

   // one adder: trial subtract for divide, accumulate for multiply
   always_comb begin
      if (ctl.step_div) begin
         add_a   = AW'({rem_ff, quo_ff[QW-1]});
         add_b   = AW'(dvs_ff);
         add_sub = 1'b1;
      end else begin
         add_a   = AW'({acc_ff, 1'b0});
         add_b   = mpr_ff[CW-1] ? AW'(mcand_ff) : '0;
         add_sub = 1'b0;
      end
      sum  = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
      fits = ~sum[AW-1];
   end

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      mcand_in = mcand_ff;
      mpr_in   = mpr_ff;
      acc_in   = acc_ff;
      if (ctl.load_div) begin
         rem_in = '0;
         quo_in = dividend;
         // zero pulses per liter divides by one
         dvs_in = (divisor == '0) ? CW'(1) : divisor;
      end else if (ctl.step_div) begin
         rem_in = fits ? sum[CW-1:0] : add_a[CW-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
      end
      if (ctl.load_mul) begin
         acc_in   = '0;
         mpr_in   = multiplier;
         mcand_in = ctl.mul_src_sale ? sale_liters : quo_ff;
      end else if (ctl.step_mul) begin
         acc_in = sum[PW-1:0];
         mpr_in = {mpr_ff[CW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      mcand_ff <= mcand_in;
      mpr_ff   <= mpr_in;
      acc_ff   <= acc_in;
   end

   assign quotient = quo_ff;
   assign product  = acc_ff;

endmodule

`default_nettype wire

// ----- sv/fssm_seq.sv -----
// sequencer stepping one request through decide, divide and multiply
`default_nettype none

module fssm_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fssm_pkg::seq_status_type status,
   output fssm_pkg::seq_ctl_type        ctl
);

   localparam int SW = fssm_pkg::STEP_WIDTH;
   localparam logic [SW-1:0] DIV_LAST = SW'(fssm_pkg::DIV_STEPS - 1);
   localparam logic [SW-1:0] MUL_LAST = SW'(fssm_pkg::MUL_STEPS - 1);

   fssm_pkg::seq_state_type state_ff, state_in;
   logic [SW-1:0]           count_ff, count_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         fssm_pkg::ST_IDLE: begin
            if (status.req_valid) state_in = fssm_pkg::ST_DECIDE;
         end
         fssm_pkg::ST_DECIDE: begin
            count_in = '0;
            state_in = status.need_sale ? fssm_pkg::ST_SALE_MUL : fssm_pkg::ST_DIVIDE;
         end
         fssm_pkg::ST_SALE_MUL: begin
            count_in = count_ff + SW'(1);
            if (count_ff == MUL_LAST) state_in = fssm_pkg::ST_SALE_TAKE;
         end
         fssm_pkg::ST_SALE_TAKE: begin
            count_in = '0;
            state_in = fssm_pkg::ST_DIVIDE;
         end
         fssm_pkg::ST_DIVIDE: begin
            count_in = count_ff + SW'(1);
            if (count_ff == DIV_LAST) state_in = fssm_pkg::ST_PRICE_LOAD;
         end
         fssm_pkg::ST_PRICE_LOAD: begin
            count_in = '0;
            state_in = fssm_pkg::ST_PRICE_MUL;
         end
         fssm_pkg::ST_PRICE_MUL: begin
            count_in = count_ff + SW'(1);
            if (count_ff == MUL_LAST) state_in = fssm_pkg::ST_DONE;
         end
         fssm_pkg::ST_DONE: begin
            if (status.rsp_free) state_in = fssm_pkg::ST_IDLE;
         end
         default: begin
            state_in = fssm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         fssm_pkg::ST_IDLE: begin
            ctl.req_ready = 1'b1;
         end
         fssm_pkg::ST_DECIDE: begin
            ctl.decide       = 1'b1;
            ctl.load_mul     = status.need_sale;
            ctl.mul_src_sale = 1'b1;
            ctl.load_div     = ~status.need_sale;
         end
         fssm_pkg::ST_SALE_MUL: begin
            ctl.step_mul = 1'b1;
         end
         fssm_pkg::ST_SALE_TAKE: begin
            ctl.sale_capture = 1'b1;
            ctl.load_div     = 1'b1;
         end
         fssm_pkg::ST_DIVIDE: begin
            ctl.step_div = 1'b1;
         end
         fssm_pkg::ST_PRICE_LOAD: begin
            ctl.load_mul = 1'b1;
         end
         fssm_pkg::ST_PRICE_MUL: begin
            ctl.step_mul = 1'b1;
         end
         fssm_pkg::ST_DONE: begin
            ctl.result_load = status.rsp_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fssm_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/flow_start_stop_meter_unit.sv -----
// top level of the flow start/stop meter: poll decisions, state and result register
`default_nettype none

// One request is one meter poll; it yields one response. After a request is taken
// the block is busy, and longer when the poll ends a service with a sale,
// and then places the response in its output register, where it may wait for the
// consumer while the next request is already accepted. The busy time is set by the
// shared add/subtract unit: 31 restoring divide steps for liters, 16 shift-add
// steps for the price and, on a sale stop, 16 more for the sale price, plus the
// decide state and the load states. If a finished response still waits when the
// next one completes, that request holds until the output register is free.
// The apb-style port always answers, but registers should only be written while
// no request is in flight, as the divisor, price and thresholds are read mid-request.
module flow_start_stop_meter_unit #(
   parameter int COUNT_WIDTH = fssm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [fssm_pkg::TIME_WIDTH-1:0]        req_now_ms,
   input  wire logic signed [fssm_pkg::TOTAL_WIDTH-1:0] req_pulse_count,
   input  wire logic                                   req_open_request,
   input  wire logic                                   req_close_request,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic      [fssm_pkg::LITERS_WIDTH-1:0]      rsp_liters_now,
   output logic      [fssm_pkg::PRICE_WIDTH-1:0]       rsp_price_now,
   output logic                                        rsp_valve_is_open,
   output logic      [fssm_pkg::MODE_WIDTH-1:0]        rsp_display_mode,
   output logic                                        rsp_flowing,
   output logic                                        rsp_in_service,
   output logic                                        rsp_service_stopped,
   output logic                                        rsp_sale_recorded,
   output logic                                        rsp_counter_clear,
   output logic      [fssm_pkg::LITERS_WIDTH-1:0]      rsp_sale_liters,
   output logic      [fssm_pkg::PRICE_WIDTH-1:0]       rsp_sale_price,
   output logic signed [fssm_pkg::TOTAL_WIDTH-1:0]     rsp_running_total,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [fssm_pkg::ADDR_WIDTH-1:0]        paddr,
   input  wire logic [fssm_pkg::DATA_WIDTH-1:0]        pwdata,
   output logic      [fssm_pkg::DATA_WIDTH-1:0]        prdata,
   output logic                                        pready
);

   localparam int TW = fssm_pkg::TIME_WIDTH;
   localparam int MW = fssm_pkg::MAG_WIDTH;
   localparam int LW = fssm_pkg::LITERS_WIDTH;
   localparam int PW = fssm_pkg::PRICE_WIDTH;
   localparam int SW = fssm_pkg::TOTAL_WIDTH;
   localparam int OW = fssm_pkg::TIMEOUT_WIDTH;

   fssm_pkg::cfg_type        cfg;
   fssm_pkg::seq_ctl_type    ctl;
   fssm_pkg::seq_status_type status;
   logic [LW-1:0]            quotient;
   logic [PW-1:0]            product;

   // magnitude of the low count bits, most negative 32-bit count saturates
   logic [COUNT_WIDTH-1:0] count_raw;
   logic [COUNT_WIDTH-1:0] count_abs;
   logic [SW-1:0]          count_wide;
   logic [MW-1:0]          mag;

   assign count_raw  = req_pulse_count[COUNT_WIDTH-1:0];
   assign count_abs  = count_raw[COUNT_WIDTH-1] ? (~count_raw + COUNT_WIDTH'(1)) : count_raw;
   assign count_wide = SW'(count_abs);
   assign mag        = count_wide[SW-1] ? {MW{1'b1}} : count_wide[MW-1:0];

   // latched request
   logic [TW-1:0] now_ff;
   logic [MW-1:0] mag_ff;
   logic          open_ff;
   logic          close_ff;
   logic [OW-1:0] timeout_ms_ff;

   // meter state
   logic [MW-1:0]      prev_mag_ff,   prev_mag_in;
   logic [SW-1:0]      total_ff,      total_in;
   logic               armed_ff,      armed_in;
   logic [TW-1:0]      begin_ff,      begin_in;
   logic [TW-1:0]      last_flow_ff,  last_flow_in;
   logic               service_ff,    service_in;
   logic               stopped_ff,    stopped_in;
   logic               valve_ff,      valve_in;
   fssm_pkg::mode_type mode_ff,       mode_in;
   logic [LW-1:0]      liters_last_ff, liters_last_in;
   logic [LW-1:0]      sale_liters_ff, sale_liters_in;
   logic [PW-1:0]      sale_price_ff,  sale_price_in;

   // per-poll event flags
   logic flow_ev_ff, stop_ev_ff, sale_ev_ff;

   // response register
   logic          rsp_valid_ff;
   logic [LW-1:0] out_liters_ff;
   logic [PW-1:0] out_price_ff;
   logic          out_valve_ff;
   logic [fssm_pkg::MODE_WIDTH-1:0] out_mode_ff;
   logic          out_flow_ff;
   logic          out_service_ff;
   logic          out_stop_ff;
   logic          out_sale_ff;
   logic [LW-1:0] out_sale_liters_ff;
   logic [PW-1:0] out_sale_price_ff;
   logic [SW-1:0] out_total_ff;

   // decide terms
   logic [MW-1:0] delta;
   logic          big;
   logic [TW-1:0] begin_eff;
   logic [TW-1:0] debounce_elapsed;
   logic [TW-1:0] quiet_elapsed;
   logic          flow_hit;
   logic          stop_hit;
   logic          need_sale;
   logic          valve_after;

   always_comb begin
      delta            = (mag_ff >= prev_mag_ff) ? (mag_ff - prev_mag_ff)
                                                 : (prev_mag_ff - mag_ff);
      big              = delta >= MW'(cfg.min_delta);
      begin_eff        = armed_ff ? begin_ff : now_ff;
      debounce_elapsed = now_ff - begin_eff;
      quiet_elapsed    = now_ff - last_flow_ff;
      flow_hit         = big && (debounce_elapsed >= TW'(cfg.debounce_ms));
      stop_hit         = !big && service_ff && (quiet_elapsed >= TW'(timeout_ms_ff));
      need_sale        = stop_hit && (liters_last_ff != '0);
      // close wins over open, both after a stop
      valve_after      = stop_hit ? 1'b0 : valve_ff;
      if (open_ff)  valve_after = 1'b1;
      if (close_ff) valve_after = 1'b0;
   end

   always_comb begin
      prev_mag_in    = prev_mag_ff;
      total_in       = total_ff;
      armed_in       = armed_ff;
      begin_in       = begin_ff;
      last_flow_in   = last_flow_ff;
      service_in     = service_ff;
      stopped_in     = stopped_ff;
      valve_in       = valve_ff;
      mode_in        = mode_ff;
      liters_last_in = liters_last_ff;
      sale_liters_in = sale_liters_ff;
      sale_price_in  = sale_price_ff;
      if (ctl.decide) begin
         prev_mag_in = mag_ff;
         total_in    = total_ff + SW'(mag_ff);
         valve_in    = valve_after;
         if (big) begin
            armed_in = ~flow_hit;
            begin_in = begin_eff;
            if (flow_hit) begin
               last_flow_in = now_ff;
               if (stopped_ff && !service_ff) begin
                  stopped_in = 1'b0;
                  service_in = 1'b1;
                  mode_in    = fssm_pkg::MODE_SERVICE;
               end
            end
         end else begin
            armed_in = 1'b0;
            if (stop_hit) begin
               last_flow_in = now_ff;
               stopped_in   = 1'b1;
               service_in   = 1'b0;
               if (need_sale) begin
                  mode_in        = fssm_pkg::MODE_SALE;
                  sale_liters_in = liters_last_ff;
               end else begin
                  mode_in        = fssm_pkg::MODE_SERVICE;
                  sale_liters_in = '0;
                  sale_price_in  = '0;
               end
            end
         end
      end
      if (ctl.sale_capture) sale_price_in = product;
      if (ctl.result_load) liters_last_in = quotient;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mag_ff    <= '0;
         total_ff       <= '0;
         armed_ff       <= 1'b0;
         begin_ff       <= '0;
         last_flow_ff   <= '0;
         service_ff     <= 1'b0;
         stopped_ff     <= 1'b1;
         valve_ff       <= 1'b0;
         mode_ff        <= fssm_pkg::MODE_IDLE;
         liters_last_ff <= '0;
         sale_liters_ff <= '0;
         sale_price_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prev_mag_ff    <= prev_mag_in;
         total_ff       <= total_in;
         armed_ff       <= armed_in;
         begin_ff       <= begin_in;
         last_flow_ff   <= last_flow_in;
         service_ff     <= service_in;
         stopped_ff     <= stopped_in;
         valve_ff       <= valve_in;
         mode_ff        <= mode_in;
         liters_last_ff <= liters_last_in;
         sale_liters_ff <= sale_liters_in;
         sale_price_ff  <= sale_price_in;
         if (ctl.result_load)    rsp_valid_ff <= 1'b1;
         else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      end
   end

   // request latch, timeout in ms and event flags
   always_ff @(posedge clock) begin
      timeout_ms_ff <= OW'(cfg.stop_timeout_s) * OW'(fssm_pkg::MS_PER_S);
      if (req_valid && ctl.req_ready) begin
         now_ff   <= req_now_ms;
         mag_ff   <= mag;
         open_ff  <= req_open_request;
         close_ff <= req_close_request;
      end
      if (ctl.decide) begin
         flow_ev_ff <= flow_hit;
         stop_ev_ff <= stop_hit;
         sale_ev_ff <= need_sale;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.result_load) begin
         out_liters_ff      <= quotient;
         out_price_ff       <= product;
         out_valve_ff       <= valve_ff;
         out_mode_ff        <= fssm_pkg::MODE_WIDTH'(mode_ff);
         out_flow_ff        <= flow_ev_ff;
         out_service_ff     <= service_ff;
         out_stop_ff        <= stop_ev_ff;
         out_sale_ff        <= sale_ev_ff;
         out_sale_liters_ff <= sale_liters_ff;
         out_sale_price_ff  <= sale_price_ff;
         out_total_ff       <= total_ff;
      end
   end

   assign status.req_valid = req_valid;
   assign status.need_sale = need_sale;
   assign status.rsp_free  = ~rsp_valid_ff | rsp_ready;

   assign req_ready           = ctl.req_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_liters_now      = out_liters_ff;
   assign rsp_price_now       = out_price_ff;
   assign rsp_valve_is_open   = out_valve_ff;
   assign rsp_display_mode    = out_mode_ff;
   assign rsp_flowing         = out_flow_ff;
   assign rsp_in_service      = out_service_ff;
   assign rsp_service_stopped = out_stop_ff;
   assign rsp_sale_recorded   = out_sale_ff;
   assign rsp_counter_clear   = out_stop_ff;
   assign rsp_sale_liters     = out_sale_liters_ff;
   assign rsp_sale_price      = out_sale_price_ff;
   assign rsp_running_total   = out_total_ff;

   fssm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fssm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   fssm_alu u_alu (
      .clock       (clock),
      .ctl         (ctl),
      .dividend    (mag_ff),
      .divisor     (cfg.pulses_per_liter),
      .sale_liters (liters_last_ff),
      .multiplier  (cfg.unit_price),
      .quotient    (quotient),
      .product     (product)
   );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench of the flow start/stop meter: scripted and random polls checked against a predictor
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      logic [fssm_pkg::TIME_WIDTH-1:0]         now_ms;
      logic signed [fssm_pkg::TOTAL_WIDTH-1:0] pulse_count;
      logic                                    open_rq;
      logic                                    close_rq;
   } poll_type;

   typedef struct packed {
      logic [fssm_pkg::LITERS_WIDTH-1:0]       liters_now;
      logic [fssm_pkg::PRICE_WIDTH-1:0]        price_now;
      logic                                    valve_is_open;
      logic [fssm_pkg::MODE_WIDTH-1:0]         display_mode;
      logic                                    flowing;
      logic                                    in_service;
      logic                                    service_stopped;
      logic                                    sale_recorded;
      logic                                    counter_clear;
      logic [fssm_pkg::LITERS_WIDTH-1:0]       sale_liters;
      logic [fssm_pkg::PRICE_WIDTH-1:0]        sale_price;
      logic signed [fssm_pkg::TOTAL_WIDTH-1:0] running_total;
   } meter_reading_type;

   typedef struct {
      int                setting;
      poll_type          poll;
      bit                typed;
      meter_reading_type known;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                    req_valid = 1'b0;
   logic                                    req_ready;
   logic [fssm_pkg::TIME_WIDTH-1:0]         req_now_ms = '0;
   logic signed [fssm_pkg::TOTAL_WIDTH-1:0] req_pulse_count = '0;
   logic                                    req_open_request = 1'b0;
   logic                                    req_close_request = 1'b0;

   logic                                    rsp_valid;
   logic                                    rsp_ready = 1'b0;
   logic [fssm_pkg::LITERS_WIDTH-1:0]       rsp_liters_now;
   logic [fssm_pkg::PRICE_WIDTH-1:0]        rsp_price_now;
   logic                                    rsp_valve_is_open;
   logic [fssm_pkg::MODE_WIDTH-1:0]         rsp_display_mode;
   logic                                    rsp_flowing;
   logic                                    rsp_in_service;
   logic                                    rsp_service_stopped;
   logic                                    rsp_sale_recorded;
   logic                                    rsp_counter_clear;
   logic [fssm_pkg::LITERS_WIDTH-1:0]       rsp_sale_liters;
   logic [fssm_pkg::PRICE_WIDTH-1:0]        rsp_sale_price;
   logic signed [fssm_pkg::TOTAL_WIDTH-1:0] rsp_running_total;

   logic                                    psel = 1'b0;
   logic                                    penable = 1'b0;
   logic                                    pwrite = 1'b0;
   logic [fssm_pkg::ADDR_WIDTH-1:0]         paddr = '0;
   logic [fssm_pkg::DATA_WIDTH-1:0]         pwdata = '0;
   logic [fssm_pkg::DATA_WIDTH-1:0]         prdata;
   logic                                    pready;

   flow_start_stop_meter_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_now_ms          (req_now_ms),
      .req_pulse_count     (req_pulse_count),
      .req_open_request    (req_open_request),
      .req_close_request   (req_close_request),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_liters_now      (rsp_liters_now),
      .rsp_price_now       (rsp_price_now),
      .rsp_valve_is_open   (rsp_valve_is_open),
      .rsp_display_mode    (rsp_display_mode),
      .rsp_flowing         (rsp_flowing),
      .rsp_in_service      (rsp_in_service),
      .rsp_service_stopped (rsp_service_stopped),
      .rsp_sale_recorded   (rsp_sale_recorded),
      .rsp_counter_clear   (rsp_counter_clear),
      .rsp_sale_liters     (rsp_sale_liters),
      .rsp_sale_price      (rsp_sale_price),
      .rsp_running_total   (rsp_running_total),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the meter
   fssm_pkg::cfg_type  meter_cfg;
   logic [31:0]        prev_mag;
   logic [31:0]        total_acc;
   logic [31:0]        debounce_start;
   logic [31:0]        last_flow_ms;
   logic               debounce_on;
   logic               service_on;
   logic               idle_halt;
   logic               valve_on;
   fssm_pkg::mode_type mode_now;
   logic [30:0]        liters_prev;
   logic [30:0]        sale_liters_held;
   logic [46:0]        sale_price_held;

   meter_reading_type pending_readings[$];
   script_row_type    script_rows[$];

   int  mismatch_count = 0;
   int  readings_seen = 0;
   int  polls_sent = 0;
   int  settings_used = 0;
   int  sales_seen = 0;
   int  empty_stops = 0;
   int  ready_hold = 0;
   bit  links_steady = 1'b0;

   // random poll generator
   logic [31:0]        gen_time;
   logic signed [31:0] gen_count;
   int                 seg_left;
   bit                 seg_flow;
   bit                 seg_up;

   function automatic fssm_pkg::cfg_type make_cfg(logic [15:0] md, logic [15:0] deb,
                                                  logic [15:0] tmo, logic [15:0] ppl,
                                                  logic [15:0] price);
      fssm_pkg::cfg_type c;
      c.min_delta        = md;
      c.debounce_ms      = deb;
      c.stop_timeout_s   = tmo;
      c.pulses_per_liter = ppl;
      c.unit_price       = price;
      return c;
   endfunction

   task automatic meter_state_reset();
      meter_cfg = make_cfg(fssm_pkg::MIN_DELTA_RESET, fssm_pkg::DEBOUNCE_MS_RESET,
                           fssm_pkg::STOP_TIMEOUT_S_RESET, fssm_pkg::PULSES_PER_LITER_RESET,
                           fssm_pkg::UNIT_PRICE_RESET);
      prev_mag = '0;
      total_acc = '0;
      debounce_start = '0;
      last_flow_ms = '0;
      debounce_on = 1'b0;
      service_on = 1'b0;
      idle_halt = 1'b1;
      valve_on = 1'b0;
      mode_now = fssm_pkg::MODE_IDLE;
      liters_prev = '0;
      sale_liters_held = '0;
      sale_price_held = '0;
   endtask

   function automatic meter_reading_type predict_reading(poll_type p);
      meter_reading_type r;
      logic [32:0] raw_mag;
      logic [31:0] mag;
      logic [31:0] delta;
      logic [31:0] divisor;
      logic [31:0] quotient;
      logic [31:0] elapsed;
      logic [63:0] limit_ms;
      logic [63:0] prod;
      r = '0;
      if (p.pulse_count[31]) begin
         raw_mag = 33'h1_0000_0000 - {1'b0, p.pulse_count};
      end else begin
         raw_mag = {1'b0, p.pulse_count};
      end
      // most negative count saturates
      mag = (raw_mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : raw_mag[31:0];
      delta = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
      divisor = (meter_cfg.pulses_per_liter == 16'd0) ? 32'd1 : {16'd0, meter_cfg.pulses_per_liter};
      limit_ms = 64'(meter_cfg.stop_timeout_s) * 64'd1000;
      if (delta >= {16'd0, meter_cfg.min_delta}) begin
         if (!debounce_on) begin
            debounce_start = p.now_ms;
            debounce_on = 1'b1;
         end
         elapsed = p.now_ms - debounce_start;
         if (elapsed >= {16'd0, meter_cfg.debounce_ms}) begin
            r.flowing = 1'b1;
            last_flow_ms = p.now_ms;
            if (idle_halt && !service_on) begin
               idle_halt = 1'b0;
               service_on = 1'b1;
               mode_now = fssm_pkg::MODE_SERVICE;
            end
            debounce_on = 1'b0;
         end
      end else begin
         debounce_on = 1'b0;
         elapsed = p.now_ms - last_flow_ms;
         if (service_on && {32'd0, elapsed} >= limit_ms) begin
            last_flow_ms = p.now_ms;
            idle_halt = 1'b1;
            service_on = 1'b0;
            valve_on = 1'b0;
            r.service_stopped = 1'b1;
            r.counter_clear = 1'b1;
            // the sale is judged on the liters of the previous poll
            if (liters_prev != '0) begin
               r.sale_recorded = 1'b1;
               mode_now = fssm_pkg::MODE_SALE;
               sale_liters_held = liters_prev;
               prod = 64'(liters_prev) * 64'(meter_cfg.unit_price);
               sale_price_held = prod[46:0];
            end else begin
               mode_now = fssm_pkg::MODE_SERVICE;
               sale_liters_held = '0;
               sale_price_held = '0;
            end
         end
      end
      total_acc = total_acc + mag;
      prev_mag = mag;
      quotient = mag / divisor;
      liters_prev = quotient[30:0];
      prod = 64'(quotient[30:0]) * 64'(meter_cfg.unit_price);
      if (p.open_rq) valve_on = 1'b1;
      if (p.close_rq) valve_on = 1'b0;
      r.liters_now = quotient[30:0];
      r.price_now = prod[46:0];
      r.valve_is_open = valve_on;
      r.display_mode = mode_now;
      r.in_service = service_on;
      r.sale_liters = sale_liters_held;
      r.sale_price = sale_price_held;
      r.running_total = total_acc;
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mismatch in %s at result %0d: expected %0h, got %0h",
                     name, readings_seen, want, got);
         end
      end
   endtask

   // result side: random stalls after accepted results, none while links_steady is set
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            hold = links_steady ? 0 : $urandom_range(0, 7);
            if (hold != 0) begin
               rsp_ready <= 1'b0;
               ready_hold <= hold;
            end
         end
      end else if (ready_hold <= 1) begin
         rsp_ready <= 1'b1;
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   always @(posedge clock) begin
      meter_reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("result %0d arrived with no request outstanding", readings_seen);
            end
         end else begin
            want = pending_readings.pop_front();
            check_field("liters_now", 64'(want.liters_now), 64'(rsp_liters_now));
            check_field("price_now", 64'(want.price_now), 64'(rsp_price_now));
            check_field("valve_is_open", 64'(want.valve_is_open), 64'(rsp_valve_is_open));
            check_field("display_mode", 64'(want.display_mode), 64'(rsp_display_mode));
            check_field("flowing", 64'(want.flowing), 64'(rsp_flowing));
            check_field("in_service", 64'(want.in_service), 64'(rsp_in_service));
            check_field("service_stopped", 64'(want.service_stopped),
                        64'(rsp_service_stopped));
            check_field("sale_recorded", 64'(want.sale_recorded), 64'(rsp_sale_recorded));
            check_field("counter_clear", 64'(want.counter_clear), 64'(rsp_counter_clear));
            check_field("sale_liters", 64'(want.sale_liters), 64'(rsp_sale_liters));
            check_field("sale_price", 64'(want.sale_price), 64'(rsp_sale_price));
            check_field("running_total", 64'(unsigned'(want.running_total)),
                        64'(unsigned'(rsp_running_total)));
         end
         readings_seen++;
      end
   end

   task automatic send_poll(poll_type p, bit typed, meter_reading_type known);
      int gap;
      meter_reading_type guess;
      gap = links_steady ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= p.now_ms;
      req_pulse_count <= p.pulse_count;
      req_open_request <= p.open_rq;
      req_close_request <= p.close_rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = predict_reading(p);
      pending_readings.push_back(typed ? known : guess);
      polls_sent++;
      if (guess.sale_recorded) sales_seen++;
      else if (guess.service_stopped) empty_stops++;
   endtask

   // hold the request side until every result is back
   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(fssm_pkg::reg_index_type idx, logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(fssm_pkg::reg_index_type idx, logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field(idx.name(), 64'({16'd0, value}), 64'(prdata));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(fssm_pkg::cfg_type c);
      settle_block();
      csr_write(fssm_pkg::REG_MIN_DELTA, c.min_delta);
      csr_write(fssm_pkg::REG_DEBOUNCE_MS, c.debounce_ms);
      csr_write(fssm_pkg::REG_STOP_TIMEOUT_S, c.stop_timeout_s);
      csr_write(fssm_pkg::REG_PULSES_PER_LITER, c.pulses_per_liter);
      csr_write(fssm_pkg::REG_UNIT_PRICE, c.unit_price);
      csr_check(fssm_pkg::REG_MIN_DELTA, c.min_delta);
      csr_check(fssm_pkg::REG_DEBOUNCE_MS, c.debounce_ms);
      csr_check(fssm_pkg::REG_STOP_TIMEOUT_S, c.stop_timeout_s);
      csr_check(fssm_pkg::REG_PULSES_PER_LITER, c.pulses_per_liter);
      csr_check(fssm_pkg::REG_UNIT_PRICE, c.unit_price);
      meter_cfg = c;
      settings_used++;
   endtask

   task automatic add_row(int setting, logic [31:0] now, logic [31:0] count, bit op, bit cl,
                          bit typed = 1'b0, meter_reading_type known = '0);
      script_row_type row;
      row.setting = setting;
      row.poll.now_ms = now;
      row.poll.pulse_count = count;
      row.poll.open_rq = op;
      row.poll.close_rq = cl;
      row.typed = typed;
      row.known = known;
      script_rows.push_back(row);
   endtask

   function automatic fssm_pkg::cfg_type random_phase_cfg(int ph);
      case (ph)
         0: return make_cfg(16'd3, 16'd20, 16'd15, 16'd100, 16'd250);
         1: return make_cfg(16'd0, 16'd0, 16'd1, 16'd1, 16'hFFFF);
         2: return make_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
         3: return make_cfg(16'd50, 16'd300, 16'd2, 16'd10, 16'd99);
         4: return make_cfg(16'd1, 16'd0, 16'd0, 16'd0, 16'd1);
         5: return make_cfg(16'($urandom_range(0, 600)), 16'($urandom_range(0, 500)),
                            16'($urandom_range(1, 5)), 16'($urandom_range(1, 2000)),
                            16'($urandom_range(0, 65535)));
         default: return make_cfg(16'd200, 16'd100, 16'd3, 16'd1000, 16'd1234);
      endcase
   endfunction

   // mostly flow bursts and quiet stretches, with some noise polls
   task automatic next_random_poll(output poll_type p);
      int pick;
      logic [31:0] step;
      logic [31:0] timeout_ms;
      pick = $urandom_range(0, 99);
      p.open_rq = ($urandom_range(0, 5) == 0);
      p.close_rq = ($urandom_range(0, 9) == 0);
      if (pick < 6) begin
         p.now_ms = $urandom;
         p.pulse_count = $urandom;
         return;
      end
      if (seg_left == 0) begin
         seg_flow = ($urandom_range(0, 9) < 6);
         seg_up = $urandom_range(0, 1);
         seg_left = seg_flow ? $urandom_range(1, 8) : $urandom_range(1, 5);
         case ($urandom_range(0, 7))
            0, 1: begin
               gen_count = '0;
            end
            2: begin
               gen_count = seg_up ? 32'sh7FFF_F000 : -32'sh7FFF_F000;
            end
            default: begin
            end
         endcase
      end
      seg_left--;
      if (seg_flow) begin
         step = meter_cfg.min_delta + $urandom_range(0, 400);
         // now and then a small change breaks the debounce run
         if ($urandom_range(0, 9) == 0) step = $urandom_range(0, meter_cfg.min_delta);
         gen_time = gen_time + $urandom_range(1, meter_cfg.debounce_ms / 2 + 40);
      end else begin
         timeout_ms = meter_cfg.stop_timeout_s * 1000;
         step = (meter_cfg.min_delta > 1) ? $urandom_range(0, meter_cfg.min_delta - 1) : 0;
         gen_time = gen_time + $urandom_range(timeout_ms / 4, timeout_ms * 3 / 4 + 500);
      end
      gen_count = seg_up ? gen_count + step : gen_count - step;
      p.now_ms = gen_time;
      p.pulse_count = gen_count;
   endtask

   initial begin
      fssm_pkg::cfg_type script_cfg[3];
      meter_reading_type known;
      poll_type          p;
      int                active;
      meter_state_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(fssm_pkg::REG_MIN_DELTA, fssm_pkg::MIN_DELTA_RESET);
      csr_check(fssm_pkg::REG_DEBOUNCE_MS, fssm_pkg::DEBOUNCE_MS_RESET);
      csr_check(fssm_pkg::REG_STOP_TIMEOUT_S, fssm_pkg::STOP_TIMEOUT_S_RESET);
      csr_check(fssm_pkg::REG_PULSES_PER_LITER, fssm_pkg::PULSES_PER_LITER_RESET);
      csr_check(fssm_pkg::REG_UNIT_PRICE, fssm_pkg::UNIT_PRICE_RESET);

      script_cfg[0] = meter_cfg;
      // zero debounce, zero timeout, zero divisor, top price
      script_cfg[1] = make_cfg(16'd1, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      // longest debounce, one-second timeout, largest divisor
      script_cfg[2] = make_cfg(16'd3, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1);

      known = '0;
      add_row(0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1, known);
      known.liters_now = 31'd21474836;
      known.running_total = 32'sh7FFF_FFFF;
      add_row(0, 32'd100, 32'h8000_0000, 1'b0, 1'b0, 1'b1, known);
      add_row(0, 32'd130, 32'h7FFF_FFFF, 1'b0, 1'b0);
      add_row(0, 32'd200, 32'd0, 1'b0, 1'b0);
      add_row(0, 32'd230, 32'd1000, 1'b1, 1'b0);
      add_row(0, 32'd300, 32'd2000, 1'b0, 1'b0);
      add_row(0, 32'd330, 32'd3000, 1'b0, 1'b0);
      add_row(0, 32'd400, 32'd3000, 1'b0, 1'b0);
      add_row(0, 32'd15330, 32'd3000, 1'b0, 1'b0);
      add_row(0, 32'd15400, 32'd0, 1'b1, 1'b1);
      add_row(0, 32'd15500, 32'd0, 1'b1, 1'b0);
      add_row(0, 32'd15600, 32'd50, 1'b0, 1'b0);
      add_row(0, 32'd15620, 32'd99, 1'b0, 1'b0);
      add_row(0, 32'd30620, 32'd99, 1'b0, 1'b1);
      add_row(1, 32'hFFFF_FF00, 32'd5, 1'b0, 1'b0);
      add_row(1, 32'hFFFF_FFF0, 32'd5, 1'b1, 1'b0);
      add_row(1, 32'h0000_0010, -32'sd7, 1'b0, 1'b0);
      add_row(1, 32'h0000_0100, -32'sd7, 1'b0, 1'b0);
      // debounce and timeout measured across the time wrap
      add_row(2, 32'hFFFF_FF00, 32'd1000, 1'b0, 1'b0);
      add_row(2, 32'h0000_FF00, 32'd2000, 1'b0, 1'b0);
      add_row(2, 32'h0001_0200, 32'd2000, 1'b0, 1'b0);
      add_row(2, 32'h0001_02E8, 32'd2000, 1'b0, 1'b0);
      add_row(2, 32'h0001_0400, 32'h7FFF_FFFF, 1'b0, 1'b0);
      add_row(2, 32'h0001_0500, 32'h8000_0001, 1'b1, 1'b1);

      active = 0;
      foreach (script_rows[i]) begin
         if (script_rows[i].setting != active) begin
            active = script_rows[i].setting;
            apply_setting(script_cfg[active]);
         end
         send_poll(script_rows[i].poll, script_rows[i].typed, script_rows[i].known);
      end

      for (int ph = 0; ph < 7; ph++) begin
         apply_setting(random_phase_cfg(ph));
         gen_time = $urandom;
         gen_count = $urandom;
         seg_left = 0;
         for (int n = 0; n < 135; n++) begin
            links_steady = (n >= 40 && n < 70);
            if ($urandom_range(0, 63) == 0) settle_block();
            next_random_poll(p);
            send_poll(p, 1'b0, '0);
         end
         links_steady = 1'b0;
      end

      settle_block();
      repeat (100) @(posedge clock);
      $display("covered %0d polls under %0d register settings, %0d results compared",
               polls_sent, settings_used + 1, readings_seen);
      $display("predicted %0d sales and %0d empty stops, %0d mismatches counted",
               sales_seen, empty_stops, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("timeout with %0d results still outstanding", pending_readings.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
sv/fssm_pkg.sv
sv/fssm_csr.sv
sv/fssm_alu.sv
sv/fssm_seq.sv
sv/flow_start_stop_meter_unit.sv
tb/tb_top.sv
